FILE: hdl/rv32_pkg.sv
// Package for the RV32I execute unit: operation codes, field widths, shared types.
// No dependencies.
package rv32_pkg;

    localparam int unsigned MemBytesDefault = 65536;
    localparam logic [2:0]  PcStepReset     = 3'd4;

    typedef enum logic [5:0] {
        K_LUI, K_AUIPC, K_JAL, K_JALR,
        K_BEQ, K_BNE, K_BLT, K_BGE, K_BLTU, K_BGEU,
        K_LB, K_LH, K_LW, K_LBU, K_LHU,
        K_SB, K_SH, K_SW,
        K_ADDI, K_SLTI, K_SLTIU, K_XORI, K_ORI, K_ANDI,
        K_SLLI, K_SRLI, K_SRAI,
        K_ADD, K_SUB, K_SLL, K_SLT, K_SLTU, K_XOR, K_SRL, K_SRA, K_OR, K_AND
    } t_kind;

    localparam logic [5:0] KindLast = 6'd36;

    typedef struct packed {
        logic [5:0]  kind;
        logic [4:0]  rd;
        logic [31:0] imm;
    } t_op;

endpackage

FILE: hdl/rv32i_execute_unit.sv
// Top level of the RV32I execute unit: register file, byte memory, pc, output stage.
// Depends on rv32_pkg and rv32_alu.
//
// Use: s_axis carries one decoded instruction per transfer; m_axis returns one
// result per instruction. The pc_step register is written on the cfg channel
// (valid/ready); the user must write it only while the unit is idle, the block does not enforce this.
// The register file is read at the input transfer. In the next cycle the
// address rs1 + imm is formed and the four byte lanes of the data memory are
// read. Then, once the output register is free, the result is computed, the
// register file and memory lanes are written and the result is loaded into
// the output register, which raises m_axis_tvalid.
// The next instruction is accepted at the edge where the current one retires,
// its operands bypassed from the retiring write, so a new instruction can enter
// while the last one finishes; the pace is set by the register read followed
// by the dependent memory read.
// When the receiver stalls, the finished result waits in the output register;
// one more instruction is accepted and holds in the execute stage until the
// output register frees, and s_axis_tready stays low meanwhile.
// Reset (synchronous, active low) clears the register file valid bits, the pc,
// pc_step (to 4) and all handshake state. Data memory is not cleared: loads
// of bytes never stored return undefined data.
module rv32i_execute_unit import rv32_pkg::*; #(
    parameter int unsigned MEM_BYTES = MemBytesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // kind[5:0], dest_reg[10:6], src_reg_a[15:11], src_reg_b[20:16], immediate[52:21], zero
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // next_pc[31:0], reg_written[32], written_reg[37:33], written_value[69:38],
    // illegal_op[70], zero
    output logic [71:0] m_axis_tdata
);
    localparam int AW    = $clog2(MEM_BYTES);
    localparam int WORDS = MEM_BYTES / 4;

    logic [2:0]  r_step;
    logic [31:0] r_pc;
    logic [31:0] rf_mem [32];
    logic [31:0] r_valid;
    logic [7:0]  mem0 [WORDS];
    logic [7:0]  mem1 [WORDS];
    logic [7:0]  mem2 [WORDS];
    logic [7:0]  mem3 [WORDS];

    // execute stage
    logic        r_busy, r_phase;
    t_op         r_op;
    logic [4:0]  r_ra, r_rb;
    logic [31:0] r_rda, r_rdb;
    logic        r_fwd_a, r_fwd_b;
    logic [31:0] r_fwd_val;
    logic [7:0]  r_ld [4];

    logic        r_ovalid;
    logic [71:0] r_odata;

    logic [5:0]  in_kind;
    logic [4:0]  in_rd, in_ra, in_rb;
    logic [31:0] in_imm;
    logic        acc_in, fire, out_free;

    logic [31:0]   a, b, ea, val, npc, load;
    logic [AW-1:0] ea_lo;
    logic [1:0]    lane_off;
    logic          wr_ok, illegal, wr;
    logic [2:0]    nbytes;
    logic [1:0]    lane_k [4];
    logic [AW-1:0] lane_addr [4];
    logic [7:0]    st_data [4];
    logic          st_en [4];

    assign in_kind = s_axis_tdata[5:0];
    assign in_rd   = s_axis_tdata[10:6];
    assign in_ra   = s_axis_tdata[15:11];
    assign in_rb   = s_axis_tdata[20:16];
    assign in_imm  = s_axis_tdata[52:21];

    assign out_free      = !r_ovalid || m_axis_tready;
    assign fire          = r_busy && r_phase && out_free;
    // take the next instruction when the stage is empty or retiring
    assign s_axis_tready = !r_busy || fire;
    assign acc_in        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // bypass the write that retired at the transfer edge
    assign a = (r_ra == 5'd0) ? 32'd0 : r_fwd_a ? r_fwd_val : r_valid[r_ra] ? r_rda : 32'd0;
    assign b = (r_rb == 5'd0) ? 32'd0 : r_fwd_b ? r_fwd_val : r_valid[r_rb] ? r_rdb : 32'd0;

    assign ea       = a + r_op.imm;
    assign ea_lo    = ea[AW-1:0];
    assign lane_off = ea_lo[1:0];

    // rotate lanes so byte 0 of the access comes first
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            load[i*8 +: 8] = r_ld[2'(i + 32'(lane_off))];
        end
    end

    rv32_alu u_alu (
        .i_kind (r_op.kind), .i_a(a), .i_b(b), .i_imm(r_op.imm), .i_pc(r_pc),
        .i_step (r_step), .i_load(load), .o_val(val), .o_npc(npc), .o_wr(wr_ok)
    );

    assign illegal = r_op.kind > KindLast;
    assign wr      = wr_ok && r_op.rd != 5'd0;

    always_comb begin
        case (r_op.kind)
            K_SB:    nbytes = 3'd1;
            K_SH:    nbytes = 3'd2;
            K_SW:    nbytes = 3'd4;
            default: nbytes = 3'd0;
        endcase
        for (int i = 0; i < 4; i++) begin
            // byte k of the access sits in lane (ea + k) mod 4
            lane_k[i]    = 2'(i - 32'(lane_off));
            lane_addr[i] = ea_lo + AW'(lane_k[i]);
            st_data[i]   = b[lane_k[i]*8 +: 8];
            st_en[i]     = fire && ({1'b0, lane_k[i]} < nbytes);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_rda     <= rf_mem[in_ra];
            r_rdb     <= rf_mem[in_rb];
            r_fwd_a   <= fire && wr && (in_ra == r_op.rd);
            r_fwd_b   <= fire && wr && (in_rb == r_op.rd);
            r_fwd_val <= val;
            r_op      <= '{kind: in_kind, rd: in_rd, imm: in_imm};
            r_ra      <= in_ra;
            r_rb      <= in_rb;
        end
        if (r_busy && !r_phase) begin
            r_ld[0] <= mem0[lane_addr[0][AW-1:2]];
            r_ld[1] <= mem1[lane_addr[1][AW-1:2]];
            r_ld[2] <= mem2[lane_addr[2][AW-1:2]];
            r_ld[3] <= mem3[lane_addr[3][AW-1:2]];
        end
        if (st_en[0]) mem0[lane_addr[0][AW-1:2]] <= st_data[0];
        if (st_en[1]) mem1[lane_addr[1][AW-1:2]] <= st_data[1];
        if (st_en[2]) mem2[lane_addr[2][AW-1:2]] <= st_data[2];
        if (st_en[3]) mem3[lane_addr[3][AW-1:2]] <= st_data[3];
        if (fire && wr) rf_mem[r_op.rd] <= val;
        if (fire) begin
            r_odata <= {1'b0, illegal, wr ? val : 32'd0, wr ? r_op.rd : 5'd0, wr, npc};
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= PcStepReset;
            r_pc     <= 32'd0;
            r_valid  <= 32'd0;
            r_busy   <= 1'b0;
            r_phase  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_step <= i_cfg_data;
            if (acc_in) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
            end else if (fire) begin
                r_busy <= 1'b0;
            end else if (r_busy && !r_phase) begin
                r_phase <= 1'b1;
            end
            if (fire) begin
                r_pc <= npc;
                if (wr) r_valid[r_op.rd] <= 1'b1;
            end
            if (fire) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

FILE: hdl/rv32_alu.sv
// Combinational ALU, branch compare and load formatting for the RV32I execute unit.
// Depends on rv32_pkg.
module rv32_alu import rv32_pkg::*; (
    input  logic [5:0]  i_kind,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_imm,
    input  logic [31:0] i_pc,
    input  logic [2:0]  i_step,
    input  logic [31:0] i_load,
    output logic [31:0] o_val,
    output logic [31:0] o_npc,
    output logic        o_wr
);
    logic [31:0] seq, ea, br_tgt;
    logic        lts, ltu, ltsi, ltui, take;

    assign seq    = i_pc + {29'd0, i_step};
    assign ea     = i_a + i_imm;
    assign br_tgt = i_pc + i_imm;
    assign lts    = $signed(i_a) < $signed(i_b);
    assign ltu    = i_a < i_b;
    assign ltsi   = $signed(i_a) < $signed(i_imm);
    assign ltui   = i_a < i_imm;

    always_comb begin
        o_val = 32'd0;
        o_npc = seq;
        o_wr  = 1'b1;
        take  = 1'b0;
        case (i_kind)
            K_LUI:   o_val = i_imm;
            K_AUIPC: o_val = br_tgt;
            K_JAL:   begin o_val = seq; o_npc = br_tgt; end
            K_JALR:  begin o_val = seq; o_npc = {ea[31:1], 1'b0}; end
            K_BEQ, K_BNE, K_BLT, K_BGE, K_BLTU, K_BGEU: begin
                o_wr = 1'b0;
                case (i_kind)
                    K_BEQ:   take = i_a == i_b;
                    K_BNE:   take = i_a != i_b;
                    K_BLT:   take = lts;
                    K_BGE:   take = !lts;
                    K_BLTU:  take = ltu;
                    default: take = !ltu;
                endcase
                if (take) o_npc = br_tgt;
            end
            K_LB:    o_val = {{24{i_load[7]}}, i_load[7:0]};
            K_LH:    o_val = {{16{i_load[15]}}, i_load[15:0]};
            K_LW:    o_val = i_load;
            K_LBU:   o_val = {24'd0, i_load[7:0]};
            K_LHU:   o_val = {16'd0, i_load[15:0]};
            K_SB, K_SH, K_SW: o_wr = 1'b0;
            K_ADDI:  o_val = ea;
            K_SLTI:  o_val = {31'd0, ltsi};
            K_SLTIU: o_val = {31'd0, ltui};
            K_XORI:  o_val = i_a ^ i_imm;
            K_ORI:   o_val = i_a | i_imm;
            K_ANDI:  o_val = i_a & i_imm;
            K_SLLI:  o_val = i_a << i_imm[4:0];
            K_SRLI:  o_val = i_a >> i_imm[4:0];
            K_SRAI:  o_val = 32'($signed(i_a) >>> i_imm[4:0]);
            K_ADD:   o_val = i_a + i_b;
            K_SUB:   o_val = i_a - i_b;
            K_SLL:   o_val = i_a << i_b[4:0];
            K_SLT:   o_val = {31'd0, lts};
            K_SLTU:  o_val = {31'd0, ltu};
            K_XOR:   o_val = i_a ^ i_b;
            K_SRL:   o_val = i_a >> i_b[4:0];
            K_SRA:   o_val = 32'($signed(i_a) >>> i_b[4:0]);
            K_OR:    o_val = i_a | i_b;
            K_AND:   o_val = i_a & i_b;
            default: begin o_wr = 1'b0; o_npc = i_pc; end
        endcase
    end
endmodule
